### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rdsi_pkg.sv
// ----------------------------------------------------------------------------
// rdsi_pkg
// Types and constants shared by the sorted-insert deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rdsi_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 64;
    localparam int OPCODE_W = 4;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_SORTED     = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_POP_BACK   = 4'd4,
        OP_PEEK_FRONT = 4'd5,
        OP_PEEK_BACK  = 4'd6,
        OP_ROT_FWD    = 4'd7,
        OP_ROT_BACK   = 4'd8
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch command and compare against all cells
        logic commit;   // apply command, load result register
    } t_dp_cmd;

    // datapath to controller / checks
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/rdsi_if.sv
// ----------------------------------------------------------------------------
// rdsi channel interfaces
// Valid/ready command and response channels of the sorted-insert deque.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdsi_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [rdsi_pkg::OPCODE_W-1:0]        opcode;
    logic signed [rdsi_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface rdsi_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rdsi_pkg::VALUE_W-1:0]  result_value;
    logic [rdsi_pkg::STATUS_W-1:0]        status;
    logic [rdsi_pkg::FILL_W-1:0]          fill_count;
    logic                                 is_empty;

    modport source (output valid, output result_value, output status,
                    output fill_count, output is_empty, input ready);
    modport sink   (input valid, input result_value, input status,
                    input fill_count, input is_empty, output ready);
endinterface

`default_nettype wire

### hw/rtl/rdsi_ctrl.sv
// ----------------------------------------------------------------------------
// rdsi_ctrl
// Command sequencer: accept, execute, and response-register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output rdsi_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_capture, w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_capture   = i_in_valid && o_in_ready;
    // hold execution while the previous response is still waiting
    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign o_cmd.capture = w_capture;
    assign o_cmd.commit  = w_commit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_capture) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rdsi_dp.sv
// ----------------------------------------------------------------------------
// rdsi_dp
// Row of compare-and-shift cells holding the deque in front-to-back order.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsi_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rdsi_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [rdsi_pkg::OPCODE_W-1:0]       i_opcode,
    input  wire logic signed [rdsi_pkg::VALUE_W-1:0] i_value,
    output logic signed [rdsi_pkg::VALUE_W-1:0]      o_result_value,
    output logic [rdsi_pkg::STATUS_W-1:0]            o_status,
    output logic [rdsi_pkg::FILL_W-1:0]              o_fill_count,
    output logic                                     o_is_empty,
    output rdsi_pkg::t_dp_stat                       o_stat
);

    localparam int CAP = rdsi_pkg::CAPACITY;
    localparam int CW  = rdsi_pkg::CNT_W;
    localparam int VW  = rdsi_pkg::VALUE_W;

    // cell i holds logical position i, counted from the front
    logic signed [VW-1:0]             r_cell [CAP];
    logic [CAP-1:0]                   r_ge;
    logic [CW-1:0]                    r_count, n_count;
    logic [rdsi_pkg::OPCODE_W-1:0]    r_op;
    logic signed [VW-1:0]             r_value;

    logic signed [VW-1:0]             r_res_value;
    rdsi_pkg::t_status                r_status;
    logic [rdsi_pkg::FILL_W-1:0]      r_fill;
    logic                             r_empty;

    logic                             w_full, w_none, w_multi;
    logic [CW-1:0]                    w_last;
    logic signed [VW-1:0]             w_back, w_ins_val, w_res;
    rdsi_pkg::t_status                w_status;
    logic                             w_do_insert, w_do_shl;
    logic                             w_mask_all, w_mask_ge, w_from_back;
    logic [CAP-1:0]                   w_mask, w_shr;
    logic signed [VW-1:0]             w_left  [CAP];
    logic signed [VW-1:0]             w_right [CAP];

    assign w_full  = (r_count == CW'(CAP));
    assign w_none  = (r_count == '0);
    assign w_multi = (r_count >= CW'(2));
    assign w_last  = r_count - CW'(1);
    assign w_back  = r_cell[w_last[rdsi_pkg::IDX_W-1:0]];
    assign w_ins_val = w_from_back ? w_back : r_value;

    // command decode
    always_comb begin
        w_do_insert = 1'b0;
        w_do_shl    = 1'b0;
        w_mask_all  = 1'b0;
        w_mask_ge   = 1'b0;
        w_from_back = 1'b0;
        w_res       = '0;
        w_status    = rdsi_pkg::ST_OK;
        n_count     = r_count;
        unique case (rdsi_pkg::t_opcode'(r_op))
            rdsi_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = rdsi_pkg::ST_FULL;
                end else begin
                    w_do_insert = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            rdsi_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = rdsi_pkg::ST_FULL;
                end else begin
                    w_do_insert = 1'b1;
                    w_mask_all  = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            rdsi_pkg::OP_SORTED: begin
                if (w_full) begin
                    w_status = rdsi_pkg::ST_FULL;
                end else begin
                    w_do_insert = 1'b1;
                    w_mask_ge   = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            rdsi_pkg::OP_POP_FRONT: begin
                if (w_none) begin
                    w_status = rdsi_pkg::ST_EMPTY;
                end else begin
                    w_res    = r_cell[0];
                    w_do_shl = 1'b1;
                    n_count  = w_last;
                end
            end
            rdsi_pkg::OP_POP_BACK: begin
                if (w_none) begin
                    w_status = rdsi_pkg::ST_EMPTY;
                end else begin
                    w_res   = w_back;
                    n_count = w_last;
                end
            end
            rdsi_pkg::OP_PEEK_FRONT: begin
                if (w_none) w_status = rdsi_pkg::ST_EMPTY;
                else        w_res    = r_cell[0];
            end
            rdsi_pkg::OP_PEEK_BACK: begin
                if (w_none) w_status = rdsi_pkg::ST_EMPTY;
                else        w_res    = w_back;
            end
            rdsi_pkg::OP_ROT_FWD: begin
                w_do_shl = w_multi;
            end
            rdsi_pkg::OP_ROT_BACK: begin
                // back entry re-enters at the front, count unchanged
                w_do_insert = w_multi;
                w_mask_all  = 1'b1;
                w_from_back = 1'b1;
            end
            default: begin
            end
        endcase
    end

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        // insert point is the first marked cell; slots past the count are marked
        assign w_mask[i] = w_mask_all || (w_mask_ge && r_ge[i]) || (CW'(i) >= r_count);

        if (i == 0) begin : g_first
            assign w_shr[i]  = 1'b0;
            assign w_left[i] = r_cell[i];
        end else begin : g_rest
            assign w_shr[i]  = |w_mask[i-1:0];
            assign w_left[i] = r_cell[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign w_right[i] = r_cell[i];
        end else begin : g_inner
            assign w_right[i] = r_cell[i+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.capture) begin
                r_ge[i] <= (i_value <= r_cell[i]);
            end
            if (i_cmd.commit) begin
                if (w_do_insert) begin
                    if (w_shr[i]) begin
                        r_cell[i] <= w_left[i];
                    end else if (w_mask[i]) begin
                        r_cell[i] <= w_ins_val;
                    end
                end else if (w_do_shl) begin
                    // advance toward the front, old front wraps to the back
                    if (CW'(i) == w_last) begin
                        r_cell[i] <= r_cell[0];
                    end else if (CW'(i) < w_last) begin
                        r_cell[i] <= w_right[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_value <= i_value;
        end
        if (i_cmd.commit) begin
            r_res_value <= w_res;
            r_status    <= w_status;
            r_fill      <= rdsi_pkg::FILL_W'(n_count);
            r_empty     <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign o_result_value = r_res_value;
    assign o_status       = r_status;
    assign o_fill_count   = r_fill;
    assign o_is_empty     = r_empty;
    assign o_stat.count   = r_count;

endmodule

`default_nettype wire

### hw/rtl/rotating_deque_sorted_insert.sv
// ----------------------------------------------------------------------------
// rotating_deque_sorted_insert
// Bounded deque of signed 64-bit values with sorted insert and rotation.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per transaction: opcode and value. o_rsp returns
//   exactly one response per command: result_value, status, fill_count and
//   is_empty after the command.
//   Sequencing: a command is accepted in S_IDLE and executes in S_EXEC; no new
//   command is accepted until it has executed. The capture step latches the
//   command and compares the value against every entry in parallel; the
//   commit step shifts the cell row and loads the response register.
//   Entries are kept front-to-back in a row of 64-bit cells, so inserts,
//   front removals and rotations are a single parallel shift.
//   Stall: while a response waits on o_rsp, the next command is still accepted
//   and compared, but its execution holds until the response is taken.
//   Reset: the entry count clears at once; no clearing pass is needed, entries
//   are unknown until written and never read before then.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rotating_deque_sorted_insert (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rdsi_cmd_if.sink    i_cmd,
    rdsi_rsp_if.source  o_rsp
);

    rdsi_pkg::t_dp_cmd  w_cmd;
    rdsi_pkg::t_dp_stat w_stat;

    rdsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    rdsi_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_opcode       (i_cmd.opcode),
        .i_value        (i_cmd.value),
        .o_result_value (o_rsp.result_value),
        .o_status       (o_rsp.status),
        .o_fill_count   (o_rsp.fill_count),
        .o_is_empty     (o_rsp.is_empty),
        .o_stat         (w_stat)
    );

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        w_stat.count <= rdsi_pkg::CNT_W'(rdsi_pkg::CAPACITY),
        "entry count exceeds capacity")

    `ASSERT_NEXT(a_count_stable, i_clk, i_rst_n, !w_cmd.commit,
        $stable(w_stat.count), "entry count changed without a command")

    `ASSERT_NEXT(a_count_step, i_clk, i_rst_n, w_cmd.commit,
        (w_stat.count == $past(w_stat.count)) ||
        (w_stat.count == $past(w_stat.count) + rdsi_pkg::CNT_W'(1)) ||
        (w_stat.count == $past(w_stat.count) - rdsi_pkg::CNT_W'(1)),
        "entry count moved by more than one")

    `ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n,
        !(w_cmd.capture && w_cmd.commit),
        "command captured while another executes")

endmodule

`default_nettype wire

### verif/rotating_deque_sorted_insert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotating_deque_sorted_insert_tb
// Self-checking bench for the sorted-insert deque. Commands go in over the
// cmd channel in bursts with random gaps, and o_rsp is stalled on a pattern
// that changes over time. Each accepted command updates a queue-based shadow
// of the deque, which predicts the response. Each response is compared field
// by field with the oldest prediction. The tests cover empty and full
// errors, extreme values, sorted placement, rotation, unused opcodes and a
// long random mix that sweeps the fill level.
// ----------------------------------------------------------------------------

module rotating_deque_sorted_insert_tb;

    typedef logic signed [rdsi_pkg::VALUE_W-1:0] t_val;

    typedef struct {
        t_val                         result_value;
        rdsi_pkg::t_status            status;
        logic [rdsi_pkg::FILL_W-1:0]  fill_count;
        logic                         is_empty;
    } t_deque_rsp;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_ONE_IN_FOUR,
        RDY_SPARSE
    } t_ready_mode;

    localparam t_val VAL_MIN     = {1'b1, {(rdsi_pkg::VALUE_W-1){1'b0}}};
    localparam t_val VAL_MAX     = {1'b0, {(rdsi_pkg::VALUE_W-1){1'b1}}};
    localparam int   OPCODE_TOP  = (1 << rdsi_pkg::OPCODE_W) - 1;
    localparam int   DRAIN_CYCLES = 16;
    localparam int   RANDOM_ITEMS = 650;

    logic i_clk;
    logic i_rst_n;

    rdsi_cmd_if cmd_ch ();
    rdsi_rsp_if rsp_ch ();

    rotating_deque_sorted_insert uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow of the deque contents, front at index 0
    t_val       deque_model[$];
    t_deque_rsp rsp_expected_q[$];

    int fail_count;
    int rsp_checked;
    int burst_left;
    int n_inserts, n_removes, n_peeks, n_rotates, n_unused;
    int n_full_err, n_empty_err, max_fill;

    t_ready_mode ready_mode;
    int          ready_mode_left;
    int unsigned ready_tick;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("timeout: responses still outstanding = %0d", rsp_expected_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic t_deque_rsp deque_step(
        input logic [rdsi_pkg::OPCODE_W-1:0] opcode,
        input t_val value);
        t_deque_rsp r;
        int         pos;
        bit         found;
        r.result_value = '0;
        r.status       = rdsi_pkg::ST_OK;
        case (opcode)
            rdsi_pkg::OP_PUSH_BACK, rdsi_pkg::OP_PUSH_FRONT, rdsi_pkg::OP_SORTED: begin
                n_inserts++;
                if (deque_model.size() >= rdsi_pkg::CAPACITY) begin
                    r.status = rdsi_pkg::ST_FULL;
                    n_full_err++;
                end else if (opcode == rdsi_pkg::OP_PUSH_BACK) begin
                    deque_model.push_back(value);
                end else if (opcode == rdsi_pkg::OP_PUSH_FRONT) begin
                    deque_model.push_front(value);
                end else begin
                    // place before the first entry that is >= value
                    pos   = deque_model.size();
                    found = 1'b0;
                    for (int i = 0; i < deque_model.size(); i++) begin
                        if (!found && value <= deque_model[i]) begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    if (pos == deque_model.size())
                        deque_model.push_back(value);
                    else
                        deque_model.insert(pos, value);
                end
            end
            rdsi_pkg::OP_POP_FRONT, rdsi_pkg::OP_POP_BACK,
            rdsi_pkg::OP_PEEK_FRONT, rdsi_pkg::OP_PEEK_BACK: begin
                if (opcode == rdsi_pkg::OP_POP_FRONT || opcode == rdsi_pkg::OP_POP_BACK)
                    n_removes++;
                else
                    n_peeks++;
                if (deque_model.size() == 0) begin
                    r.status = rdsi_pkg::ST_EMPTY;
                    n_empty_err++;
                end else begin
                    case (opcode)
                        rdsi_pkg::OP_POP_FRONT:  r.result_value = deque_model.pop_front();
                        rdsi_pkg::OP_POP_BACK:   r.result_value = deque_model.pop_back();
                        rdsi_pkg::OP_PEEK_FRONT: r.result_value = deque_model[0];
                        default:                 r.result_value = deque_model[$];
                    endcase
                end
            end
            rdsi_pkg::OP_ROT_FWD: begin
                n_rotates++;
                if (deque_model.size() >= 2)
                    deque_model.push_back(deque_model.pop_front());
            end
            rdsi_pkg::OP_ROT_BACK: begin
                n_rotates++;
                if (deque_model.size() >= 2)
                    deque_model.push_front(deque_model.pop_back());
            end
            default: n_unused++;
        endcase
        r.fill_count = rdsi_pkg::FILL_W'(deque_model.size());
        r.is_empty   = (deque_model.size() == 0);
        if (deque_model.size() > max_fill)
            max_fill = deque_model.size();
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            rsp_expected_q.push_back(deque_step(cmd_ch.opcode, cmd_ch.value));
    end

    // ------------------------------------------------------------------
    // Response checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t, response %0d, %s: got 0x%h, want 0x%h",
                 $realtime, rsp_checked, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_deque_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_expected_q.size() == 0) begin
                report_mismatch("response with no command pending",
                                rsp_ch.result_value, '0);
            end else begin
                want = rsp_expected_q.pop_front();
                if (rsp_ch.result_value !== want.result_value)
                    report_mismatch("result_value", rsp_ch.result_value,
                                    want.result_value);
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                if (rsp_ch.fill_count !== want.fill_count)
                    report_mismatch("fill_count", 64'(rsp_ch.fill_count),
                                    64'(want.fill_count));
                if (rsp_ch.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 64'(rsp_ch.is_empty),
                                    64'(want.is_empty));
            end
            rsp_checked++;
        end
    end

    // response backpressure: switch between stall patterns every so often
    initial begin
        rsp_ch.ready    <= 1'b0;
        ready_mode_left = 0;
        ready_tick      = 0;
        forever begin
            @(posedge i_clk);
            if (ready_mode_left == 0) begin
                ready_mode      = t_ready_mode'($urandom_range(RDY_ALWAYS, RDY_SPARSE));
                ready_mode_left = $urandom_range(16, 96);
            end
            ready_mode_left--;
            ready_tick++;
            case (ready_mode)
                RDY_ALWAYS:      rsp_ch.ready <= 1'b1;
                RDY_COIN:        rsp_ch.ready <= 1'($urandom_range(0, 1));
                RDY_ONE_IN_FOUR: rsp_ch.ready <= (ready_tick[1:0] == 2'b00);
                default:         rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_cmd(input logic [rdsi_pkg::OPCODE_W-1:0] opcode,
                            input t_val value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        cmd_ch.valid  <= 1'b1;
        cmd_ch.opcode <= opcode;
        cmd_ch.value  <= value;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    function automatic t_val random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_val'(int'($urandom_range(0, 16)) - 8);
            4, 5, 6, 7: return {$urandom, $urandom};
            8:          return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            default:    return t_val'(int'($urandom_range(0, 2)) - 1);
        endcase
    endfunction

    task automatic test_empty_deque();
        send_cmd(rdsi_pkg::OP_POP_FRONT,  {$urandom, $urandom});
        send_cmd(rdsi_pkg::OP_POP_BACK,   VAL_MAX);
        send_cmd(rdsi_pkg::OP_PEEK_FRONT, VAL_MIN);
        send_cmd(rdsi_pkg::OP_PEEK_BACK,  -1);
        send_cmd(rdsi_pkg::OP_ROT_FWD,    {$urandom, $urandom});
        send_cmd(rdsi_pkg::OP_ROT_BACK,   {$urandom, $urandom});
    endtask

    task automatic test_sole_entry();
        send_cmd(rdsi_pkg::OP_PUSH_FRONT, 5);
        send_cmd(rdsi_pkg::OP_ROT_FWD,    0);   // single entry: no change
        send_cmd(rdsi_pkg::OP_ROT_BACK,   0);
        send_cmd(rdsi_pkg::OP_POP_FRONT,  0);   // empties the deque
        send_cmd(rdsi_pkg::OP_PUSH_BACK,  -3);
        send_cmd(rdsi_pkg::OP_POP_BACK,   0);
    endtask

    task automatic test_sorted_extremes();
        send_cmd(rdsi_pkg::OP_SORTED,     VAL_MAX);
        send_cmd(rdsi_pkg::OP_SORTED,     VAL_MIN);
        send_cmd(rdsi_pkg::OP_SORTED,     0);
        send_cmd(rdsi_pkg::OP_SORTED,     VAL_MIN);   // equal to front: goes ahead of it
        send_cmd(rdsi_pkg::OP_SORTED,     VAL_MAX);   // equal to back: lands before it
        send_cmd(rdsi_pkg::OP_PEEK_FRONT, 0);
        send_cmd(rdsi_pkg::OP_PEEK_BACK,  0);
    endtask

    task automatic test_rotation();
        send_cmd(rdsi_pkg::OP_ROT_FWD,    0);
        send_cmd(rdsi_pkg::OP_PEEK_BACK,  0);
        send_cmd(rdsi_pkg::OP_ROT_BACK,   0);
        send_cmd(rdsi_pkg::OP_PEEK_FRONT, 0);
    endtask

    task automatic test_unused_opcodes();
        send_cmd(rdsi_pkg::OPCODE_W'(rdsi_pkg::OP_ROT_BACK + 1), '1);
        send_cmd(rdsi_pkg::OPCODE_W'(OPCODE_TOP),                {$urandom, $urandom});
    endtask

    // fill past capacity, hit full on every insert kind, then drain past empty
    task automatic test_capacity();
        rdsi_pkg::t_opcode ins;
        for (int k = 0; k < rdsi_pkg::CAPACITY; k++) begin
            case ($urandom_range(0, 2))
                0:       ins = rdsi_pkg::OP_PUSH_BACK;
                1:       ins = rdsi_pkg::OP_PUSH_FRONT;
                default: ins = rdsi_pkg::OP_SORTED;
            endcase
            send_cmd(ins, random_value());
        end
        send_cmd(rdsi_pkg::OP_PUSH_BACK,  VAL_MAX);
        send_cmd(rdsi_pkg::OP_PUSH_FRONT, VAL_MIN);
        send_cmd(rdsi_pkg::OP_SORTED,     0);
        send_cmd(rdsi_pkg::OP_ROT_FWD,    0);
        send_cmd(rdsi_pkg::OP_ROT_BACK,   0);
        send_cmd(rdsi_pkg::OP_PEEK_FRONT, 0);
        send_cmd(rdsi_pkg::OP_PEEK_BACK,  0);
        for (int k = 0; k < rdsi_pkg::CAPACITY + 4; k++)
            send_cmd($urandom_range(0, 1) ? rdsi_pkg::OP_POP_FRONT : rdsi_pkg::OP_POP_BACK,
                     random_value());
    endtask

    // fill level wanders between empty and full; some phases insert only in sorted order
    task automatic test_random_traffic(input int n_items);
        int                            target;
        int                            phase_left;
        bit                            sorted_only;
        int                            roll;
        int                            fill;
        bit                            grow;
        logic [rdsi_pkg::OPCODE_W-1:0] op;
        phase_left = 0;
        target     = 0;
        for (int k = 0; k < n_items; k++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 3))
                    0:       target = 0;
                    1:       target = $urandom_range(1, 4);
                    2:       target = $urandom_range(5, rdsi_pkg::CAPACITY - 2);
                    default: target = rdsi_pkg::CAPACITY;
                endcase
                sorted_only = ($urandom_range(0, 2) == 0);
            end
            phase_left--;
            fill = deque_model.size();
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                op = rdsi_pkg::OPCODE_W'($urandom_range(rdsi_pkg::OP_ROT_BACK + 1,
                                                        OPCODE_TOP));
            end else if (roll < 12) begin
                op = $urandom_range(0, 1) ? rdsi_pkg::OP_ROT_FWD : rdsi_pkg::OP_ROT_BACK;
            end else if (roll < 22) begin
                op = $urandom_range(0, 1) ? rdsi_pkg::OP_PEEK_FRONT
                                          : rdsi_pkg::OP_PEEK_BACK;
            end else begin
                grow = (fill < target) ? (roll < 85) : (roll >= 88);
                if (!grow)
                    op = $urandom_range(0, 1) ? rdsi_pkg::OP_POP_FRONT
                                              : rdsi_pkg::OP_POP_BACK;
                else if (sorted_only)
                    op = rdsi_pkg::OP_SORTED;
                else
                    case ($urandom_range(0, 2))
                        0:       op = rdsi_pkg::OP_PUSH_BACK;
                        1:       op = rdsi_pkg::OP_PUSH_FRONT;
                        default: op = rdsi_pkg::OP_SORTED;
                    endcase
            end
            send_cmd(op, random_value());
        end
    endtask

    initial begin
        fail_count  = 0;
        rsp_checked = 0;
        burst_left  = 0;
        n_inserts   = 0;
        n_removes   = 0;
        n_peeks     = 0;
        n_rotates   = 0;
        n_unused    = 0;
        n_full_err  = 0;
        n_empty_err = 0;
        max_fill    = 0;

        i_rst_n       <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.opcode <= rdsi_pkg::OP_PUSH_BACK;
        cmd_ch.value  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_deque();
        test_sole_entry();
        test_sorted_extremes();
        test_rotation();
        test_unused_opcodes();
        test_capacity();
        test_random_traffic(RANDOM_ITEMS);

        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d responses: %0d inserts, %0d removes, %0d peeks,",
                 rsp_checked, n_inserts, n_removes, n_peeks);
        $display("%0d rotates, %0d unused; full rejects %0d, empty rejects %0d,",
                 n_rotates, n_unused, n_full_err, n_empty_err);
        $display("peak fill %0d of %0d, mismatches %0d",
                 max_fill, rdsi_pkg::CAPACITY, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
